// ===== hw/rtl/sfd_pkg.sv =====
package sfd_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } sfd_in_t;

  typedef struct packed {
    logic              status_code;
    logic              powered_on;
    logic [7:0]        battery_protect;
    logic signed [7:0] target_temp;
    logic signed [7:0] actual_temp;
  } sfd_out_t;

  localparam logic       MODE_BYTE     = 1'b0;
  localparam logic       MODE_DROP     = 1'b1;
  localparam logic       CODE_OK       = 1'b0;
  localparam logic       CODE_SHORT    = 1'b1;
  localparam logic [7:0] SYNC_BYTE     = 8'hFE;
  localparam logic [7:0] STATUS_CMD    = 8'h01;
  localparam logic [8:0] MIN_FRAME_LEN = 9'd16;

  localparam logic [7:0] IDX_CMD       = 8'd0;
  localparam logic [7:0] IDX_POWER     = 8'd2;
  localparam logic [7:0] IDX_BATTERY   = 8'd4;
  localparam logic [7:0] IDX_TARGET    = 8'd5;
  localparam logic [7:0] IDX_ACTUAL    = 8'd15;

endpackage

// ===== hw/rtl/status_frame_deframer.sv =====
// Status frame deframer: takes one received byte (or a link-drop marker) per beat, hunts
// for the FE FE sync, reads the length byte and the body, and when a frame with command
// 0x01 ends it gives one status result, code 1 if the length byte is under 16. The
// checksum is not checked. A new beat is taken every cycle as long as results are taken;
// a beat passes an input register and the frame parser into the result register, so its
// result shows on the output once the result register holds it. A link-drop beat
// returns to sync hunting.
module status_frame_deframer import sfd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sfd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sfd_out_t out_data
);

  sfd_in_t  in_r;
  logic     in_valid_r;
  sfd_out_t out_r;
  logic     out_valid_r;
  logic     advance;
  logic     res_valid;
  sfd_out_t res;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  sfd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .beat      (in_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (out_ready || !out_valid_r) out_valid_r <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_data;
    if (advance && res_valid) out_r <= res;
  end

endmodule

// ===== hw/rtl/sfd_parse.sv =====
module sfd_parse import sfd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step_en,
  input  sfd_in_t  beat,
  output logic     res_valid,
  output sfd_out_t res
);

  typedef enum logic [1:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_LEN,
    PH_BODY
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] idx_r, idx_nxt;
  logic       cmd_ok_r, cmd_ok_nxt;
  logic       power_r, power_nxt;
  logic [7:0] batt_r, batt_nxt;
  logic [7:0] target_r, target_nxt;
  logic [7:0] actual_r, actual_nxt;
  logic       more;

  assign more = ({1'b0, idx_r} + 9'd1) < {1'b0, len_r};

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    cmd_ok_nxt = cmd_ok_r;
    power_nxt  = power_r;
    batt_nxt   = batt_r;
    target_nxt = target_r;
    actual_nxt = actual_r;
    res_valid  = 1'b0;
    res        = '0;
    if (beat.mode == MODE_DROP) begin
      phase_nxt  = PH_HUNT1;
      len_nxt    = '0;
      idx_nxt    = '0;
      cmd_ok_nxt = 1'b0;
      power_nxt  = 1'b0;
      batt_nxt   = '0;
      target_nxt = '0;
      actual_nxt = '0;
    end else begin
      unique case (phase_r)
        PH_HUNT1: begin
          if (beat.data_byte == SYNC_BYTE) phase_nxt = PH_HUNT2;
        end
        PH_HUNT2: begin
          phase_nxt = (beat.data_byte == SYNC_BYTE) ? PH_LEN : PH_HUNT1;
        end
        PH_LEN: begin
          len_nxt    = beat.data_byte;
          idx_nxt    = '0;
          cmd_ok_nxt = 1'b0;
          power_nxt  = 1'b0;
          batt_nxt   = '0;
          target_nxt = '0;
          actual_nxt = '0;
          phase_nxt  = (beat.data_byte == 8'd0) ? PH_HUNT1 : PH_BODY;
        end
        PH_BODY: begin
          if (idx_r == IDX_CMD)     cmd_ok_nxt = (beat.data_byte == STATUS_CMD);
          if (idx_r == IDX_POWER)   power_nxt  = (beat.data_byte != 8'd0);
          if (idx_r == IDX_BATTERY) batt_nxt   = beat.data_byte;
          if (idx_r == IDX_TARGET)  target_nxt = beat.data_byte;
          if (idx_r == IDX_ACTUAL)  actual_nxt = beat.data_byte;
          if (more) begin
            idx_nxt = idx_r + 8'd1;
          end else begin
            phase_nxt = PH_HUNT1;
            idx_nxt   = '0;
            res_valid = cmd_ok_nxt;
            if ({1'b0, len_r} >= MIN_FRAME_LEN) begin
              res.status_code     = CODE_OK;
              res.powered_on      = power_nxt;
              res.battery_protect = batt_nxt;
              res.target_temp     = target_nxt;
              res.actual_temp     = actual_nxt;
            end else begin
              res.status_code = CODE_SHORT;
            end
          end
        end
        default: phase_nxt = PH_HUNT1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT1;
      len_r    <= '0;
      idx_r    <= '0;
      cmd_ok_r <= 1'b0;
      power_r  <= 1'b0;
      batt_r   <= '0;
      target_r <= '0;
      actual_r <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
      cmd_ok_r <= cmd_ok_nxt;
      power_r  <= power_nxt;
      batt_r   <= batt_nxt;
      target_r <= target_nxt;
      actual_r <= actual_nxt;
    end
  end

endmodule

// ===== hw/rtl/sfd_checker.sv =====
module sfd_assertions import sfd_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input sfd_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status_code == CODE_SHORT |->
      !out_data.powered_on && out_data.battery_protect == 8'd0 &&
      out_data.target_temp == 8'sd0 && out_data.actual_temp == 8'sd0)
    else $error("short status carries nonzero fields");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

  a_reset_idle: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind status_frame_deframer sfd_assertions u_sfd_assertions (.*);

// ===== verif/sfd_checker.sv =====
`timescale 1ns / 1ps
module sfd_checker import sfd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  sfd_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  sfd_out_t out_data,
  output int       fail_count,
  output int       outstanding
);

  typedef enum logic [1:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    READ_LENGTH,
    READ_BODY
  } deframe_phase_t;

  deframe_phase_t phase_q;
  logic [7:0]     length_q;
  logic [7:0]     index_q;
  logic           cmd_is_status;
  logic           power_q;
  logic [7:0]     battery_q;
  logic [7:0]     target_q;
  logic [7:0]     actual_q;
  sfd_out_t       expected_status[$];
  sfd_out_t       oldest_status;

  task automatic clear_captures();
    cmd_is_status = 1'b0;
    power_q       = 1'b0;
    battery_q     = 8'd0;
    target_q      = 8'd0;
    actual_q      = 8'd0;
  endtask

  task automatic clear_deframer();
    phase_q  = HUNT_FIRST;
    length_q = 8'd0;
    index_q  = 8'd0;
    clear_captures();
  endtask

  task automatic advance_deframer(input sfd_in_t beat);
    sfd_out_t status;
    if (beat.mode == MODE_DROP) begin
      clear_deframer();
    end else begin
      case (phase_q)
        HUNT_FIRST: begin
          if (beat.data_byte == SYNC_BYTE) phase_q = HUNT_SECOND;
        end
        HUNT_SECOND: begin
          phase_q = (beat.data_byte == SYNC_BYTE) ? READ_LENGTH : HUNT_FIRST;
        end
        READ_LENGTH: begin
          length_q = beat.data_byte;
          index_q  = 8'd0;
          clear_captures();
          phase_q  = (beat.data_byte == 8'd0) ? HUNT_FIRST : READ_BODY;
        end
        default: begin
          case (index_q)
            IDX_CMD:     cmd_is_status = (beat.data_byte == STATUS_CMD);
            IDX_POWER:   power_q = (beat.data_byte != 8'd0);
            IDX_BATTERY: battery_q = beat.data_byte;
            IDX_TARGET:  target_q = beat.data_byte;
            IDX_ACTUAL:  actual_q = beat.data_byte;
            default: ;
          endcase
          if ({1'b0, index_q} + 9'd1 < {1'b0, length_q}) begin
            index_q = index_q + 8'd1;
          end else begin
            phase_q = HUNT_FIRST;
            index_q = 8'd0;
            if (cmd_is_status) begin
              if ({1'b0, length_q} >= MIN_FRAME_LEN) begin
                status = '{CODE_OK, power_q, battery_q, target_q, actual_q};
              end else begin
                status = '{CODE_SHORT, 1'b0, 8'd0, 8'sd0, 8'sd0};
              end
              expected_status.push_back(status);
            end
          end
        end
      endcase
    end
  endtask

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %02h got %02h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_deframer();
      expected_status.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          fail_count++;
          $display("%0t: result expected none got %p", $time, out_data);
        end else begin
          oldest_status = expected_status.pop_front();
          check_field("status_code", 8'(oldest_status.status_code), 8'(out_data.status_code));
          check_field("powered_on", 8'(oldest_status.powered_on), 8'(out_data.powered_on));
          check_field("battery_protect", oldest_status.battery_protect,
                      out_data.battery_protect);
          check_field("target_temp", oldest_status.target_temp, out_data.target_temp);
          check_field("actual_temp", oldest_status.actual_temp, out_data.actual_temp);
        end
      end
      if (in_valid && in_ready) advance_deframer(in_data);
    end
    outstanding = expected_status.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import sfd_pkg::*;

  localparam int BEAT_TARGET = 1650;
  localparam int CYCLE_LIMIT = 300000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     out_ready = 1'b0;
  sfd_in_t  in_data   = '0;
  logic     in_ready;
  logic     out_valid;
  sfd_out_t out_data;
  int       fail_count;
  int       outstanding;
  int       beats_sent  = 0;
  int       cycle_count = 0;
  logic     steady      = 1'b0;

  always #5 clk = ~clk;

  status_frame_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sfd_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_beat(input logic mode, input logic [7:0] value);
    if (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode, value};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_byte(input logic [7:0] value);
    send_beat(MODE_BYTE, value);
  endtask

  task automatic send_drop();
    send_beat(MODE_DROP, 8'($urandom));
  endtask

  function automatic logic [7:0] non_sync_byte();
    logic [7:0] value;
    do value = 8'($urandom); while (value == SYNC_BYTE);
    return value;
  endfunction

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_frame();
    int unsigned pick;
    int unsigned frame_len;
    int unsigned drop_at;
    logic [7:0]  cmd;
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 3)) send_byte(non_sync_byte());
    end
    if ($urandom_range(99) < 8) begin
      send_byte(SYNC_BYTE);
      send_byte(non_sync_byte());
    end
    pick = $urandom_range(99);
    if (pick < 50) frame_len = $urandom_range(16, 20);
    else if (pick < 85) frame_len = $urandom_range(1, 15);
    else if (pick < 92) frame_len = 0;
    else if (pick < 97) frame_len = $urandom_range(21, 60);
    else if (pick < 98) frame_len = SYNC_BYTE;
    else frame_len = $urandom_range(1) ? 255 : $urandom_range(61, 255);
    cmd     = ($urandom_range(99) < 70) ? STATUS_CMD : 8'($urandom);
    drop_at = ($urandom_range(99) < 6) ? $urandom_range(0, frame_len) : frame_len + 1;
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    if (drop_at == 0 && frame_len == 0) begin
      send_drop();
    end else begin
      send_byte(8'(frame_len));
      for (int i = 0; i < frame_len; i++) begin
        if (i == drop_at) begin
          send_drop();
          break;
        end
        send_byte((i == 0) ? cmd : payload_byte());
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // link drop straight after reset, then broken sync
    send_drop();
    send_byte(8'h00);
    send_byte(SYNC_BYTE);
    send_byte(8'h12);
    // zero length
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'h00);
    // short status
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'h01);
    send_byte(STATUS_CMD);
    // other command
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'h02);
    send_byte(8'h07);
    send_byte(8'hFF);
    // triple sync, third byte taken as length, then dropped
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(STATUS_CMD);
    send_drop();

    while (beats_sent < BEAT_TARGET) begin
      steady = (beats_sent >= 600 && beats_sent < 950);
      if ($urandom_range(99) < 5) begin
        send_beat(1'($urandom_range(1)), 8'($urandom));
      end else begin
        send_frame();
      end
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
